FILE: hw/rtl/bah_pkg.sv
// bah_pkg: shared constants for the block averaging histogram
// item mode codes, field widths, the lowest-value reset value and the bin saturation limit; no dependencies
package bah_pkg;

  localparam int unsigned DATA_W = 12;
  localparam int unsigned BIN_W  = 16;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_FLUSH  = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [DATA_W-1:0] LOW_RESET = {DATA_W{1'b1}};
  localparam logic [BIN_W-1:0]  BIN_MAX   = {BIN_W{1'b1}};

endpackage

FILE: hw/rtl/bah_ram.sv
// bah_ram: generic single-port RAM, read-first, registered read data
// no dependencies
module bah_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hw/rtl/bah_div.sv
// bah_div: iterative restoring divider, one quotient bit per cycle
// gives a DATA_W-bit quotient for a dividend known to divide below 2**DATA_W; uses bah_pkg
module bah_div #(
  parameter int unsigned FILL_W = 7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [bah_pkg::DATA_W+FILL_W-1:0] dividend,
  input  logic [FILL_W-1:0]               divisor,
  output logic                            done,
  output logic [bah_pkg::DATA_W-1:0]      quotient
);

  localparam int unsigned DW    = bah_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(DW);

  logic [FILL_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]     shf_r, shf_nxt;
  logic [FILL_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [FILL_W+1:0] diff;

  assign diff = {1'b0, rem_r, shf_r[DW-1]} - {2'b00, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    shf_nxt  = shf_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[DW+FILL_W-1:DW];
      shf_nxt  = dividend[DW-1:0];
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[FILL_W+1]) begin
        rem_nxt = diff[FILL_W-1:0];
        shf_nxt = {shf_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[FILL_W-2:0], shf_r[DW-1]};
        shf_nxt = {shf_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    shf_r <= shf_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = shf_r;

endmodule

FILE: hw/rtl/block_average_histogram_top.sv
// block_average_histogram_top: sample block averaging into a saturating bin histogram
// sequencer, block accumulator and statistics; uses bah_pkg, bah_div and bah_ram
//
// One item is taken at a time and in_ready stays low while it is worked on. A sample
// that does not complete a block goes from the execute step straight to the output step;
// a sample or flush that bins an average starts the 12-step shared divider and then does
// a read-modify-write of the bin memory; a read fetches one bin from the memory; a clear
// zeroes one bin per cycle. After reset the block zeroes the bin memory before it takes
// its first item; configuration is taken at any time and belongs between items. A
// finished result waits in the output register while the next item is taken; while that
// register is still held by out_ready low, the next result waits in its last step and
// stretches the item by the stall.
module block_average_histogram_top #(
  parameter int unsigned BIN_COUNT = 4096,
  parameter int unsigned MAX_BLOCK = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_block_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [11:0] in_sample,
  input  logic [11:0] in_bin_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_average_valid,
  output logic [11:0] out_average_value,
  output logic [15:0] out_bin_value,
  output logic [11:0] out_lowest_value,
  output logic [11:0] out_highest_value,
  output logic [15:0] out_peak_count,
  output logic        out_histogram_empty
);

  localparam int unsigned DW     = bah_pkg::DATA_W;
  localparam int unsigned BW     = bah_pkg::BIN_W;
  localparam int unsigned ADDR_W = $clog2(BIN_COUNT);
  localparam int unsigned FILL_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUM_W  = DW + FILL_W;
  localparam logic [16:0] BIN_LIMIT = 17'(BIN_COUNT);
  localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(BIN_COUNT - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_BRD  = 3'd4;
  localparam logic [2:0] S_RDW  = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [6:0]        size_r;
  logic [1:0]        mode_r, mode_nxt;
  logic [DW-1:0]     sample_r, sample_nxt;
  logic [DW-1:0]     index_r, index_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [DW-1:0]     low_r, low_nxt;
  logic [DW-1:0]     high_r, high_nxt;
  logic [BW-1:0]     peak_r, peak_nxt;
  logic              empty_r, empty_nxt;
  logic              avgv_r, avgv_nxt;
  logic [DW-1:0]     avg_r, avg_nxt;
  logic [BW-1:0]     binv_r, binv_nxt;
  logic [ADDR_W-1:0] bidx_r, bidx_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;

  logic              ov_r, ov_nxt;
  logic              oavgv_r, oavgv_nxt;
  logic [DW-1:0]     oavg_r, oavg_nxt;
  logic [BW-1:0]     obin_r, obin_nxt;
  logic [DW-1:0]     olow_r, olow_nxt;
  logic [DW-1:0]     ohigh_r, ohigh_nxt;
  logic [BW-1:0]     opeak_r, opeak_nxt;
  logic              oempty_r, oempty_nxt;

  logic [FILL_W-1:0] eff_size;
  logic [SUM_W-1:0]  sum_add;
  logic [FILL_W-1:0] fill_add;
  logic              div_start;
  logic [SUM_W-1:0]  div_dividend;
  logic [FILL_W-1:0] div_divisor;
  logic              div_done;
  logic [DW-1:0]     div_q;
  logic [ADDR_W-1:0] q_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [BW-1:0]     ram_wdata;
  logic [BW-1:0]     ram_rdata;
  logic [BW:0]       bin_add;
  logic [BW-1:0]     bin_sat;

  // effective block size: zero acts as one, capped at the largest block
  always_comb begin
    if (size_r == 7'd0) begin
      eff_size = FILL_W'(1);
    end else if ({2'b00, size_r} > 9'(MAX_BLOCK)) begin
      eff_size = FILL_W'(MAX_BLOCK);
    end else begin
      eff_size = FILL_W'(size_r);
    end
  end

  assign sum_add  = sum_r + SUM_W'(sample_r);
  assign fill_add = fill_r + FILL_W'(1);
  assign q_addr   = ({5'b0, div_q} >= BIN_LIMIT) ? LAST_BIN : ADDR_W'(div_q);
  assign bin_add  = {1'b0, ram_rdata} + (BW + 1)'(eff_size);
  assign bin_sat  = bin_add[BW] ? bah_pkg::BIN_MAX : bin_add[BW-1:0];

  assign div_dividend = (mode_r == bah_pkg::MODE_SAMPLE) ? sum_add : sum_r;
  assign div_divisor  = (mode_r == bah_pkg::MODE_SAMPLE) ? fill_add : fill_r;

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    sample_nxt = sample_r;
    index_nxt  = index_r;
    sum_nxt    = sum_r;
    fill_nxt   = fill_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    peak_nxt   = peak_r;
    empty_nxt  = empty_r;
    avgv_nxt   = avgv_r;
    avg_nxt    = avg_r;
    binv_nxt   = binv_r;
    bidx_nxt   = bidx_r;
    clr_nxt    = clr_r;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = bidx_r;
    ram_wdata  = '0;

    ov_nxt     = ov_r;
    oavgv_nxt  = oavgv_r;
    oavg_nxt   = oavg_r;
    obin_nxt   = obin_r;
    olow_nxt   = olow_r;
    ohigh_nxt  = ohigh_r;
    opeak_nxt  = opeak_r;
    oempty_nxt = oempty_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_INIT, S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == LAST_BIN) begin
          clr_nxt   = '0;
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          sample_nxt = in_sample;
          index_nxt  = in_bin_index;
          avgv_nxt   = 1'b0;
          avg_nxt    = '0;
          binv_nxt   = '0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_r)
          bah_pkg::MODE_SAMPLE: begin
            sum_nxt  = sum_add;
            fill_nxt = fill_add;
            if (fill_add >= eff_size) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_DONE;
            end
          end
          bah_pkg::MODE_FLUSH: begin
            if (fill_r != '0) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_DONE;
            end
          end
          bah_pkg::MODE_READ: begin
            ram_addr = ADDR_W'(index_r);
            if ({5'b0, index_r} < BIN_LIMIT) begin
              state_nxt = S_RDW;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: begin
            low_nxt   = bah_pkg::LOW_RESET;
            high_nxt  = '0;
            peak_nxt  = '0;
            empty_nxt = 1'b1;
            clr_nxt   = '0;
            state_nxt = S_CLR;
          end
        endcase
      end
      S_DIV: begin
        ram_addr = q_addr;
        if (div_done) begin
          avg_nxt   = div_q;
          bidx_nxt  = q_addr;
          state_nxt = S_BRD;
        end
      end
      S_BRD: begin
        ram_we    = 1'b1;
        ram_wdata = bin_sat;
        avgv_nxt  = 1'b1;
        if (bin_sat > peak_r) begin
          peak_nxt = bin_sat;
        end
        if (avg_r < low_r) begin
          low_nxt = avg_r;
        end
        if (avg_r > high_r) begin
          high_nxt = avg_r;
        end
        empty_nxt = 1'b0;
        sum_nxt   = '0;
        fill_nxt  = '0;
        state_nxt = S_DONE;
      end
      S_RDW: begin
        binv_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt     = 1'b1;
          oavgv_nxt  = avgv_r;
          oavg_nxt   = avg_r;
          obin_nxt   = binv_r;
          olow_nxt   = low_r;
          ohigh_nxt  = high_r;
          opeak_nxt  = peak_r;
          oempty_nxt = empty_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
      size_r  <= 7'd1;
      sum_r   <= '0;
      fill_r  <= '0;
      low_r   <= bah_pkg::LOW_RESET;
      high_r  <= '0;
      peak_r  <= '0;
      empty_r <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_valid) begin
        size_r <= cfg_block_size;
      end
      sum_r   <= sum_nxt;
      fill_r  <= fill_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      peak_r  <= peak_nxt;
      empty_r <= empty_nxt;
      ov_r    <= ov_nxt;
    end
    mode_r   <= mode_nxt;
    sample_r <= sample_nxt;
    index_r  <= index_nxt;
    avgv_r   <= avgv_nxt;
    avg_r    <= avg_nxt;
    binv_r   <= binv_nxt;
    bidx_r   <= bidx_nxt;
    oavgv_r  <= oavgv_nxt;
    oavg_r   <= oavg_nxt;
    obin_r   <= obin_nxt;
    olow_r   <= olow_nxt;
    ohigh_r  <= ohigh_nxt;
    opeak_r  <= opeak_nxt;
    oempty_r <= oempty_nxt;
  end

  bah_div #(
    .FILL_W (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  bah_ram #(
    .WIDTH (BW),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign cfg_ready           = 1'b1;
  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = ov_r;
  assign out_average_valid   = oavgv_r;
  assign out_average_value   = oavg_r;
  assign out_bin_value       = obin_r;
  assign out_lowest_value    = olow_r;
  assign out_highest_value   = ohigh_r;
  assign out_peak_count      = opeak_r;
  assign out_histogram_empty = oempty_r;

endmodule

FILE: verif/testbench.sv
// testbench: self-checking bench for block_average_histogram_top
// drives samples, flushes, reads and clears under random idling and checks each result
// against an in-bench histogram predictor; depends on bah_pkg and the top level rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BINS    = 4096;
  localparam int unsigned MAX_BLK = 64;
  localparam int unsigned LIMIT   = 1_000_000;
  localparam int unsigned SETTLE  = 40;

  typedef struct packed {
    logic                       avg_valid;
    logic [bah_pkg::DATA_W-1:0] avg_value;
    logic [bah_pkg::BIN_W-1:0]  bin_value;
    logic [bah_pkg::DATA_W-1:0] lowest_value;
    logic [bah_pkg::DATA_W-1:0] highest_value;
    logic [bah_pkg::BIN_W-1:0]  peak_count;
    logic                       is_empty;
  } hist_stats_t;

  class hist_scoreboard;
    logic [bah_pkg::BIN_W-1:0]  bin_counts [BINS];
    logic [17:0]                block_sum;
    logic [6:0]                 block_fill;
    logic [6:0]                 size_reg;
    logic [bah_pkg::DATA_W-1:0] lowest;
    logic [bah_pkg::DATA_W-1:0] highest;
    logic [bah_pkg::DATA_W-1:0] last_average;
    logic [bah_pkg::BIN_W-1:0]  peak;
    logic                       empty;
    hist_stats_t                pending_stats[$];
    int unsigned                failures;

    function void clear_bins();
      foreach (bin_counts[i]) bin_counts[i] = '0;
      lowest  = bah_pkg::LOW_RESET;
      highest = '0;
      peak    = '0;
      empty   = 1'b1;
    endfunction

    function void power_up();
      clear_bins();
      block_sum    = '0;
      block_fill   = '0;
      size_reg     = 7'd1;
      last_average = '0;
      failures     = 0;
    endfunction

    function int unsigned weight();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_BLK) return MAX_BLK;
      return size_reg;
    endfunction

    function logic [bah_pkg::DATA_W-1:0] bin_block();
      int unsigned avg;
      int unsigned slot;
      int unsigned count;
      avg   = (int'(block_sum) / int'(block_fill)) & 32'hFFF;
      slot  = (avg >= BINS) ? BINS - 1 : avg;
      count = bin_counts[slot] + weight();
      if (count > bah_pkg::BIN_MAX) count = bah_pkg::BIN_MAX;
      bin_counts[slot] = bah_pkg::BIN_W'(count);
      if (count > peak) peak = bah_pkg::BIN_W'(count);
      if (avg < lowest) lowest = bah_pkg::DATA_W'(avg);
      if (avg > highest) highest = bah_pkg::DATA_W'(avg);
      empty        = 1'b0;
      block_sum    = '0;
      block_fill   = '0;
      last_average = bah_pkg::DATA_W'(avg);
      return bah_pkg::DATA_W'(avg);
    endfunction

    function void absorb_item(logic [1:0] mode, logic [bah_pkg::DATA_W-1:0] sample,
                              logic [bah_pkg::DATA_W-1:0] index);
      hist_stats_t want;
      want = '0;
      case (mode)
        bah_pkg::MODE_SAMPLE: begin
          block_sum  += sample;
          block_fill += 1;
          if (block_fill >= weight()) begin
            want.avg_value = bin_block();
            want.avg_valid = 1'b1;
          end
        end
        bah_pkg::MODE_FLUSH: begin
          if (block_fill != 0) begin
            want.avg_value = bin_block();
            want.avg_valid = 1'b1;
          end
        end
        bah_pkg::MODE_READ: begin
          if (index < BINS) want.bin_value = bin_counts[index];
        end
        default: begin
          clear_bins();
        end
      endcase
      want.lowest_value  = lowest;
      want.highest_value = highest;
      want.peak_count    = peak;
      want.is_empty      = empty;
      pending_stats.push_back(want);
    endfunction

    function void field_check(string label, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      end
    endfunction

    function void match_stats(hist_stats_t got);
      hist_stats_t want;
      if (pending_stats.size() == 0) begin
        failures++;
        $display("%0t: result transfer with nothing expected", $time);
        return;
      end
      want = pending_stats.pop_front();
      field_check("average_valid", want.avg_valid, got.avg_valid);
      field_check("average_value", want.avg_value, got.avg_value);
      field_check("bin_value", want.bin_value, got.bin_value);
      field_check("lowest_value", want.lowest_value, got.lowest_value);
      field_check("highest_value", want.highest_value, got.highest_value);
      field_check("peak_count", want.peak_count, got.peak_count);
      field_check("histogram_empty", want.is_empty, got.is_empty);
    endfunction
  endclass

  logic        clk                 = 1'b0;
  logic        rst_n               = 1'b0;
  logic        cfg_valid           = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_block_size      = '0;
  logic        in_valid            = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode             = bah_pkg::MODE_SAMPLE;
  logic [11:0] in_sample           = '0;
  logic [11:0] in_bin_index        = '0;
  logic        out_valid;
  logic        out_ready           = 1'b0;
  logic        out_average_valid;
  logic [11:0] out_average_value;
  logic [15:0] out_bin_value;
  logic [11:0] out_lowest_value;
  logic [11:0] out_highest_value;
  logic [15:0] out_peak_count;
  logic        out_histogram_empty;
  bit          steady              = 1'b0;

  hist_scoreboard sb;

  block_average_histogram_top #(
    .BIN_COUNT(BINS),
    .MAX_BLOCK(MAX_BLK)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_block_size     (cfg_block_size),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_sample          (in_sample),
    .in_bin_index       (in_bin_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_average_valid  (out_average_valid),
    .out_average_value  (out_average_value),
    .out_bin_value      (out_bin_value),
    .out_lowest_value   (out_lowest_value),
    .out_highest_value  (out_highest_value),
    .out_peak_count     (out_peak_count),
    .out_histogram_empty(out_histogram_empty)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned idle_draw();
    return steady ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [11:0] any12();
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic send_item(logic [1:0] mode, logic [11:0] sample, logic [11:0] index);
    int unsigned gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_sample    <= sample;
    in_bin_index <= index;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.absorb_item(mode, sample, index);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic write_block_size(logic [6:0] value);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_block_size <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.size_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item(int center);
    int unsigned pick;
    int          level;
    logic [11:0] index;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      if ($urandom_range(0, 1) == 1) begin
        level = center + int'($urandom_range(0, 6)) - 3;
        if (level < 0) level = 0;
        if (level > 4095) level = 4095;
      end else begin
        level = int'(any12());
      end
      send_item(bah_pkg::MODE_SAMPLE, 12'(level), any12());
    end else if (pick < 80) begin
      send_item(bah_pkg::MODE_FLUSH, any12(), any12());
    end else if (pick < 98) begin
      index = ($urandom_range(0, 1) == 1) ? sb.last_average : any12();
      send_item(bah_pkg::MODE_READ, any12(), index);
    end else begin
      send_item(bah_pkg::MODE_CLEAR, any12(), any12());
    end
  endtask

  // stretches of back-to-back traffic on both sides
  initial begin
    forever begin
      repeat ($urandom_range(150, 500)) @(posedge clk);
      steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int unsigned stall;
    forever begin
      stall = idle_draw();
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.match_stats('{out_average_valid, out_average_value, out_bin_value,
                       out_lowest_value, out_highest_value, out_peak_count,
                       out_histogram_empty});
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int          center;
    logic [6:0]  size_pick;
    sb = new();
    sb.power_up();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // zero size behaves as one, extremes of sample and bin index
    write_block_size(7'd0);
    send_item(bah_pkg::MODE_READ, any12(), 12'd0);
    send_item(bah_pkg::MODE_FLUSH, any12(), any12());
    send_item(bah_pkg::MODE_SAMPLE, 12'd4095, any12());
    send_item(bah_pkg::MODE_SAMPLE, 12'd0, any12());
    send_item(bah_pkg::MODE_READ, any12(), 12'd4095);
    send_item(bah_pkg::MODE_READ, any12(), 12'd0);
    send_item(bah_pkg::MODE_CLEAR, any12(), any12());
    send_item(bah_pkg::MODE_READ, any12(), 12'd4095);

    // oversize register clamps, partial block flushed by its own count
    wait_drained();
    write_block_size(7'd127);
    send_item(bah_pkg::MODE_SAMPLE, 12'd4095, any12());
    send_item(bah_pkg::MODE_SAMPLE, 12'd4095, any12());
    send_item(bah_pkg::MODE_SAMPLE, 12'd1, any12());
    send_item(bah_pkg::MODE_FLUSH, any12(), any12());
    send_item(bah_pkg::MODE_READ, any12(), 12'd2730);

    // size shrinks under a partly filled block
    wait_drained();
    write_block_size(7'd8);
    for (int i = 0; i < 5; i++) begin
      send_item(bah_pkg::MODE_SAMPLE, 12'(100 + 37 * i), any12());
    end
    wait_drained();
    write_block_size(7'd3);
    send_item(bah_pkg::MODE_SAMPLE, 12'd7, any12());
    send_item(bah_pkg::MODE_READ, any12(), sb.last_average);

    // clear keeps the pending block
    send_item(bah_pkg::MODE_SAMPLE, 12'd50, any12());
    send_item(bah_pkg::MODE_CLEAR, any12(), any12());
    send_item(bah_pkg::MODE_FLUSH, any12(), any12());
    send_item(bah_pkg::MODE_READ, any12(), 12'd50);

    // single-sample flushes add full weight to one bin
    wait_drained();
    write_block_size(7'd64);
    repeat (20) begin
      send_item(bah_pkg::MODE_SAMPLE, 12'd2048, any12());
      send_item(bah_pkg::MODE_FLUSH, any12(), any12());
    end
    send_item(bah_pkg::MODE_READ, any12(), 12'd2048);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       size_pick = 7'd1;
        1:       size_pick = 7'd64;
        2:       size_pick = 7'd127;
        3:       size_pick = 7'd0;
        4:       size_pick = 7'($urandom_range(0, 127));
        default: size_pick = 7'($urandom_range(2, 9));
      endcase
      wait_drained();
      write_block_size(size_pick);
      center = int'($urandom_range(0, 4095));
      repeat (72) random_item(center);
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bah_pkg.sv
hw/rtl/bah_ram.sv
hw/rtl/bah_div.sv
hw/rtl/block_average_histogram_top.sv
verif/testbench.sv
